// ===== src/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants
// Payload structs, format codes and character constants for the radix unit.
// ----------------------------------------------------------------------------
`default_nettype none
package itoa_pkg;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned MaxDigits = 32;
  localparam int unsigned CntWidth = 6;
  localparam int unsigned DecDigits = 10;

  localparam logic [2:0] FMT_PLAIN = 3'd0;
  localparam logic [2:0] FMT_BIN = 3'd1;
  localparam logic [2:0] FMT_OCT = 3'd2;
  localparam logic [2:0] FMT_DEC = 3'd3;
  localparam logic [2:0] FMT_HEX = 3'd4;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_O = 8'h6f;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [0:0] ADDR_MAX_LENGTH = 1'b0;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  format;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       overflow;
  } out_item_t;

  // Job handed from the converter to the serializer
  typedef struct packed {
    logic [MaxDigits-1:0][3:0] digits;  // digit 0 is least significant
    logic [CntWidth-1:0]       ndig;
    logic [7:0]                suffix;
    logic                      ovf;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (CH_A + {4'd0, d} - 8'd10);
  endfunction
endpackage
`default_nettype wire

// ===== src/itoa_bcd.sv =====
// ----------------------------------------------------------------------------
// itoa_bcd: pipelined binary to BCD converter
// Double-dabble, four bits per stage over eight register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module itoa_bcd (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire itoa_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output itoa_pkg::in_item_t       out_item,
  output logic [39:0]              out_bcd
);
  localparam int Stages = 8;
  localparam int DecDigitsL = itoa_pkg::DecDigits;

  logic [Stages-1:0]             vld;
  itoa_pkg::in_item_t            itm [Stages];
  logic [39:0]                   bcd [Stages];
  logic [31:0]                   sh [Stages];
  logic [Stages-1:0]             adv;

  function automatic logic [39:0] dab(input logic [39:0] b);
    logic [39:0] r;
    r = b;
    for (int i = 0; i < DecDigitsL; i++) begin
      if (r[4*i +: 4] > 4'd4) r[4*i +: 4] = r[4*i +: 4] + 4'd3;
    end
    dab = r;
  endfunction

  // step four bits: shift in MSBs of the remaining value
  function automatic logic [71:0] step4(input logic [39:0] b, input logic [31:0] s);
    logic [39:0] r;
    logic [31:0] t;
    r = b;
    t = s;
    for (int k = 0; k < 4; k++) begin
      r = dab(r);
      r = {r[38:0], t[31]};
      t = {t[30:0], 1'b0};
    end
    step4 = {r, t};
  endfunction

  always_comb begin
    adv[Stages-1] = !vld[Stages-1] || out_ready;
    for (int i = Stages-2; i >= 0; i--) adv[i] = !vld[i] || adv[i+1];
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < Stages; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      itm[0] <= in_item;
      {bcd[0], sh[0]} <= step4(40'd0, in_item.value);
    end
    for (int i = 1; i < Stages; i++) begin
      if (adv[i]) begin
        itm[i] <= itm[i-1];
        {bcd[i], sh[i]} <= step4(bcd[i-1], sh[i-1]);
      end
    end
  end

  assign out_valid = vld[Stages-1];
  assign out_item  = itm[Stages-1];
  assign out_bcd   = bcd[Stages-1];
endmodule
`default_nettype wire

// ===== src/itoa_count.sv =====
// ----------------------------------------------------------------------------
// itoa_count: digit selection and length check
// Picks the digit vector for the radix, counts digits, tests the buffer fit.
// ----------------------------------------------------------------------------
`default_nettype none
module itoa_count (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [6:0]         max_length,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire itoa_pkg::in_item_t in_item,
  input  wire logic [39:0]        in_bcd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output itoa_pkg::job_t          out_job
);
  // stage A: digit vector and suffix; stage B: count and fit
  logic                            va, vb;
  logic [itoa_pkg::MaxDigits-1:0][3:0] dg_a;
  logic [7:0]                      suf_a;
  logic [itoa_pkg::MaxDigits-1:0]  nz_a;
  itoa_pkg::job_t                  job_b;
  logic                            adv_a, adv_b;
  logic [itoa_pkg::MaxDigits-1:0][3:0] dg_n;
  logic [7:0]                      suf_n;
  logic [itoa_pkg::MaxDigits-1:0]  nz_n;
  logic [itoa_pkg::CntWidth-1:0]   cnt_n;
  logic [6:0]                      tot_n;

  assign adv_b = !vb || out_ready;
  assign adv_a = !va || adv_b;
  assign in_ready = adv_a;

  always_comb begin
    dg_n = '0;
    unique case (in_item.format)
      itoa_pkg::FMT_BIN: begin
        suf_n = itoa_pkg::CH_B;
        for (int i = 0; i < 32; i++) dg_n[i] = {3'd0, in_item.value[i]};
      end
      itoa_pkg::FMT_OCT: begin
        suf_n = itoa_pkg::CH_O;
        for (int i = 0; i < 11; i++) begin
          dg_n[i] = {1'b0, 3'(({1'b0, in_item.value} >> (3*i)) & 33'h7)};
        end
      end
      itoa_pkg::FMT_HEX: begin
        suf_n = itoa_pkg::CH_H;
        for (int i = 0; i < 8; i++) dg_n[i] = in_item.value[4*i +: 4];
      end
      itoa_pkg::FMT_DEC: begin
        suf_n = itoa_pkg::CH_D;
        for (int i = 0; i < 10; i++) dg_n[i] = in_bcd[4*i +: 4];
      end
      default: begin
        suf_n = itoa_pkg::CH_NUL;
        for (int i = 0; i < 10; i++) dg_n[i] = in_bcd[4*i +: 4];
      end
    endcase
    for (int i = 0; i < 32; i++) nz_n[i] = (dg_n[i] != 4'd0);
  end

  // highest nonzero digit position plus one, at least one
  always_comb begin
    cnt_n = 6'd1;
    for (int i = 1; i < 32; i++) if (nz_a[i]) cnt_n = 6'(i + 1);
    tot_n = {1'b0, cnt_n} + ((suf_a != itoa_pkg::CH_NUL) ? 7'd1 : 7'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (adv_a) va <= in_valid;
      if (adv_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      dg_a <= dg_n;
      suf_a <= suf_n;
      nz_a <= nz_n;
    end
    if (adv_b) begin
      job_b.digits <= dg_a;
      job_b.ndig <= cnt_n;
      job_b.suffix <= suf_a;
      job_b.ovf <= tot_n > max_length;
    end
  end

  assign out_valid = vb;
  assign out_job = job_b;
endmodule
`default_nettype wire

// ===== src/itoa_emit.sv =====
// ----------------------------------------------------------------------------
// itoa_emit: character serializer
// Holds a job; sends digits and suffix (skipped on overflow), then NUL, one per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module itoa_emit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire itoa_pkg::job_t     in_job,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output itoa_pkg::out_item_t     out_item
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIG = 2'd1;
  localparam logic [1:0] S_SUF = 2'd2;
  localparam logic [1:0] S_NUL = 2'd3;

  logic [1:0]                    state, state_next;
  itoa_pkg::job_t                job;
  logic [itoa_pkg::CntWidth-1:0] idx, idx_next;
  logic                          take, fire;

  assign fire = out_valid && out_ready;
  // accept the next job as the terminator of this one leaves
  assign in_ready = (state == S_IDLE) || (state == S_NUL && out_ready);
  assign take = in_valid && in_ready;
  assign out_valid = (state != S_IDLE);

  always_comb begin
    out_item = '{character: itoa_pkg::CH_NUL, last: 1'b0, overflow: 1'b0};
    unique case (state)
      S_DIG: out_item.character = itoa_pkg::digit_char(job.digits[idx[4:0]]);
      S_SUF: out_item.character = job.suffix;
      S_NUL: begin
        out_item.last = 1'b1;
        out_item.overflow = job.ovf;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    if (take) begin
      state_next = in_job.ovf ? S_NUL : S_DIG;
      idx_next = in_job.ndig - 6'd1;
    end else if (fire) begin
      unique case (state)
        S_DIG: begin
          if (idx == '0) begin
            state_next = (job.suffix != itoa_pkg::CH_NUL) ? S_SUF : S_NUL;
          end
          idx_next = idx - 6'd1;
        end
        S_SUF: state_next = S_NUL;
        S_NUL: state_next = S_IDLE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (take) job <= in_job;
  end
endmodule
`default_nettype wire

// ===== src/integer_to_ascii_radix_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit: unsigned integer to ASCII string
// Converts a 32-bit value to binary, octal, decimal or hex text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_item) takes a value and a format.
//   Output channel (out_valid/out_ready/out_item) sends one character per
//   transfer, most significant digit first, then the suffix letter if any, then a
//   NUL marked last. A string that exceeds max_length gives only the NUL
//   with overflow set.
//   max_length is written over the APB port at address 0; the user must do
//   so only while idle, as the block does not enforce it. Path from input
//   to first character: 8 double-dabble, 2 select/count, 1 serializer stage.
//   The serializer sends one character per cycle while out_ready is high
//   and takes the next item as the NUL of the last one leaves; the converter
//   pipeline keeps accepting items while the serializer is busy, until full.
//   Reset clears all valid bits and sets max_length to 64.
//   When the receiver stalls, the current character holds and the
//   pipeline fills, then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
module integer_to_ascii_radix_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire itoa_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output itoa_pkg::out_item_t       out_item,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [0:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  logic [6:0]          max_length;
  logic                b_valid, b_ready, c_valid, c_ready;
  itoa_pkg::in_item_t  b_item;
  logic [39:0]         b_bcd;
  itoa_pkg::job_t      c_job;

  assign pready = 1'b1;
  assign prdata = (paddr == itoa_pkg::ADDR_MAX_LENGTH) ? {25'd0, max_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= 7'd64;
    end else if (psel && penable && pwrite && paddr == itoa_pkg::ADDR_MAX_LENGTH) begin
      max_length <= pwdata[6:0];
    end
  end

  itoa_bcd u_bcd (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item), .out_bcd(b_bcd)
  );

  itoa_count u_count (
    .clk, .rst, .max_length, .in_valid(b_valid), .in_ready(b_ready),
    .in_item(b_item), .in_bcd(b_bcd),
    .out_valid(c_valid), .out_ready(c_ready), .out_job(c_job)
  );

  itoa_emit u_emit (
    .clk, .rst, .in_valid(c_valid), .in_ready(c_ready), .in_job(c_job),
    .out_valid, .out_ready, .out_item
  );
endmodule
`default_nettype wire

// ===== src/itoa_checker.sv =====
// ----------------------------------------------------------------------------
// itoa_checker: port-level checks
// Watches the output stream of the radix unit.
// ----------------------------------------------------------------------------
`default_nettype none
module itoa_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire itoa_pkg::out_item_t out_item
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output changed under stall");
  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.overflow |-> out_item.last)
    else $error("overflow off terminator");
  a_nul_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last |-> out_item.character == itoa_pkg::CH_NUL)
    else $error("terminator not NUL");
  // reset empties the output
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
  a_chr_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |-> out_item.character != itoa_pkg::CH_NUL)
    else $error("NUL before end");
endmodule

bind integer_to_ascii_radix_unit itoa_checker u_itoa_checker (
  .clk, .rst, .out_valid, .out_ready, .out_item
);
`default_nettype wire
